>>> rtl/gcdu_pkg.sv
// constants, types and helper functions for the great-circle distance unit
`timescale 1ns / 1ps

package gcdu_pkg;

    typedef logic [31:0]        turn_t;
    typedef logic signed [32:0] trig_t;
    typedef logic signed [33:0] vec_t;

    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    localparam trig_t       INV_GAIN_Q30 = 33'sd652032874;
    localparam logic [29:0] METER_SCALE  = 30'd781801713;
    localparam logic [62:0] METER_HALF   = 63'd625 << 26;
    localparam logic [35:0] SAT_LIMIT    = 36'd12512500625;
    localparam logic [20:0] RECIP_625    = 21'd1717987;
    localparam logic [24:0] DIST_MAX     = 25'd20020000;

    // remainder by 45 of a value below 4100
    function automatic logic [5:0] mod45(input logic [12:0] x);
        logic [23:0]        p;
        logic [6:0]         qh;
        logic signed [13:0] r;
        p  = 24'(x) * 24'd1457;
        qh = p[22:16];
        r  = $signed({1'b0, x}) - $signed(14'({7'b0, qh} * 14'd45));
        if (r < 0)
        begin
            r = r + 14'sd45;
        end
        return r[5:0];
    endfunction

    // inverse of an odd number modulo 2^32
    function automatic logic [31:0] inv_mod32(input logic [31:0] a);
        logic [31:0] x;
        x = a;
        for (int k = 0; k < 5; k++)
        begin
            x = x * (32'd2 - a * x);
        end
        return x;
    endfunction

    localparam logic [31:0] INV45 = inv_mod32(32'd45);

endpackage

>>> rtl/great_circle_distance_unit.sv
// great-circle distance unit: pipelined cordic datapath, one coordinate pair per cycle
// throughput: one word per cycle; the whole pipeline holds while a result word is stalled
// the stage chain is angle conversion, three parallel sin/cos cordic lanes, products,
// a 32-stage square root, an arc-cosine cordic and the meter scaling
// reset clears all valid bits at once; data registers are not reset
`timescale 1ns / 1ps

module great_circle_distance_unit
    import gcdu_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 22,
    parameter int CORDIC_STEPS    = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [29:0] lat_a,
    input  logic signed [30:0] lon_a,
    input  logic signed [29:0] lat_b,
    input  logic signed [30:0] lon_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [24:0]        distance_m
);

    localparam int N     = CORDIC_STEPS;
    localparam int LAST  = 49 + 2 * N;
    localparam int S_P3  = 10 + N;
    localparam int S_SQ  = 43 + N;
    localparam int TSH   = 29 - ANGLE_FRAC_BITS;
    localparam int TMOD  = (1 << TSH) % 45;

    logic              adv;
    logic [LAST:0]     vld_reg;
    logic [LAST:0]     eq_reg;

    assign adv       = !(vld_reg[LAST] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eq_reg <= {eq_reg[LAST-1:0], (lat_a == lat_b) && (lon_a == lon_b)};
        end
    end

    // input capture: two latitudes and the longitude difference
    logic signed [31:0] lane_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg[0] <= {{2{lat_a[29]}}, lat_a};
            lane_reg[1] <= {{2{lat_b[29]}}, lat_b};
            lane_reg[2] <= {lon_a[30], lon_a} - {lon_b[30], lon_b};
        end
    end

    // per-lane angle conversion and sin/cos cordic
    logic [31:0]        t1_n_reg    [0:2];
    logic               t1_neg_reg  [0:2];
    logic [12:0]        t1_fold_reg [0:2];
    logic [31:0]        t2_n_reg    [0:2];
    logic               t2_neg_reg  [0:2];
    logic [5:0]         t2_am_reg   [0:2];
    logic [31:0]        t3_n_reg    [0:2];
    logic               t3_neg_reg  [0:2];
    logic [5:0]         t3_r_reg    [0:2];
    turn_t              t4_q_reg    [0:2];
    logic               t4_neg_reg  [0:2];
    turn_t              t5_turn_reg [0:2];
    trig_t              cx_reg      [0:2][0:N];
    trig_t              cy_reg      [0:2][0:N];
    logic signed [31:0] cz_reg      [0:2][0:N-1];
    logic [1:0]         cq_reg      [0:2][0:N];
    trig_t              c_reg       [0:2];
    trig_t              s_reg       [0:1];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic [31:0] abs_next;
        logic [31:0] n_next;
        logic [13:0] csum_next;
        logic [12:0] fold_next;
        turn_t       sh_next;
        trig_t       c_next;
        trig_t       s_next;

        always_comb
        begin
            abs_next  = lane_reg[l][31] ? 32'(-lane_reg[l]) : 32'(lane_reg[l]);
            n_next    = 32'(abs_next << TSH) + 32'd22;
            csum_next = {2'b0, abs_next[11:0]} + {2'b0, abs_next[23:12]}
                      + {6'b0, abs_next[31:24]};
            fold_next = {1'b0, csum_next[11:0]} + {11'b0, csum_next[13:12]};
            sh_next   = t5_turn_reg[l] + 32'h2000_0000;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                t1_n_reg[l]    <= n_next;
                t1_neg_reg[l]  <= lane_reg[l][31];
                t1_fold_reg[l] <= fold_next;
                t2_n_reg[l]    <= t1_n_reg[l];
                t2_neg_reg[l]  <= t1_neg_reg[l];
                t2_am_reg[l]   <= mod45(t1_fold_reg[l]);
                t3_n_reg[l]    <= t2_n_reg[l];
                t3_neg_reg[l]  <= t2_neg_reg[l];
                t3_r_reg[l]    <= mod45(13'({7'b0, t2_am_reg[l]} * 13'(TMOD) + 13'd22));
                t4_q_reg[l]    <= 32'((t3_n_reg[l] - {26'b0, t3_r_reg[l]}) * INV45);
                t4_neg_reg[l]  <= t3_neg_reg[l];
                t5_turn_reg[l] <= t4_neg_reg[l] ? 32'(-t4_q_reg[l]) : t4_q_reg[l];
                cq_reg[l][0]   <= sh_next[31:30];
                cz_reg[l][0]   <= $signed({2'b00, sh_next[29:0]}) - 32'sh2000_0000;
                cx_reg[l][0]   <= INV_GAIN_Q30;
                cy_reg[l][0]   <= '0;
            end
        end

        for (genvar i = 0; i < N; i++)
        begin : g_iter
            trig_t              x_next;
            trig_t              y_next;
            logic signed [31:0] z_next;

            always_comb
            begin
                if (!cz_reg[l][i][31])
                begin
                    x_next = cx_reg[l][i] - (cy_reg[l][i] >>> i);
                    y_next = cy_reg[l][i] + (cx_reg[l][i] >>> i);
                    z_next = cz_reg[l][i] - $signed(ATAN_TURNS[i]);
                end
                else
                begin
                    x_next = cx_reg[l][i] + (cy_reg[l][i] >>> i);
                    y_next = cy_reg[l][i] - (cx_reg[l][i] >>> i);
                    z_next = cz_reg[l][i] + $signed(ATAN_TURNS[i]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cx_reg[l][i+1] <= x_next;
                    cy_reg[l][i+1] <= y_next;
                    cq_reg[l][i+1] <= cq_reg[l][i];
                end
            end

            if (i < N - 1)
            begin : g_z
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        cz_reg[l][i+1] <= z_next;
                    end
                end
            end
        end

        always_comb
        begin
            case (cq_reg[l][N])
                2'd0:
                begin
                    c_next = cx_reg[l][N];
                    s_next = cy_reg[l][N];
                end
                2'd1:
                begin
                    c_next = -cy_reg[l][N];
                    s_next = cx_reg[l][N];
                end
                2'd2:
                begin
                    c_next = -cx_reg[l][N];
                    s_next = -cy_reg[l][N];
                end
                default:
                begin
                    c_next = cy_reg[l][N];
                    s_next = -cx_reg[l][N];
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_reg[l] <= c_next;
            end
        end

        if (l < 2)
        begin : g_sin
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    s_reg[l] <= s_next;
                end
            end
        end
    end

    // dot product and clamp
    logic signed [65:0] ss_prod;
    logic signed [65:0] cc_prod;
    logic signed [66:0] pc_prod;
    logic signed [33:0] ss_reg;
    logic signed [33:0] pcc_reg;
    trig_t              cd_reg;
    logic signed [33:0] ss2_reg;
    logic signed [33:0] pc_reg;
    logic signed [34:0] dsum_next;
    logic signed [31:0] d_next;
    logic signed [31:0] d_reg;

    always_comb
    begin
        ss_prod   = s_reg[0] * s_reg[1];
        cc_prod   = c_reg[0] * c_reg[1];
        pc_prod   = pcc_reg * cd_reg;
        dsum_next = 35'(ss2_reg) + 35'(pc_reg);
        if (dsum_next > 35'sd1073741824)
        begin
            d_next = 32'sd1073741824;
        end
        else if (dsum_next < -35'sd1073741824)
        begin
            d_next = -32'sd1073741824;
        end
        else
        begin
            d_next = 32'(dsum_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss_reg  <= ss_prod[63:30];
            pcc_reg <= cc_prod[63:30];
            cd_reg  <= c_reg[2];
            ss2_reg <= ss_reg;
            pc_reg  <= pc_prod[63:30];
            d_reg   <= d_next;
        end
    end

    // square root of 1 - d^2
    logic [63:0]        dd_next;
    logic [62:0]        sv_reg [0:31];
    logic [62:0]        sr_reg [0:32];
    logic signed [31:0] sd_reg [0:32];

    assign dd_next = 64'(d_reg * d_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sv_reg[0] <= 63'((64'd1 << 60) - dd_next);
            sr_reg[0] <= '0;
            sd_reg[0] <= d_reg;
        end
    end

    for (genvar k = 0; k < 32; k++)
    begin : g_sqrt
        localparam logic [62:0] BIT = 63'd1 << (62 - 2 * k);
        logic [62:0] trial_next;
        logic        ge_next;

        always_comb
        begin
            trial_next = sr_reg[k] + BIT;
            ge_next    = sv_reg[k] >= trial_next;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sr_reg[k+1] <= ge_next ? (sr_reg[k] >> 1) + BIT : sr_reg[k] >> 1;
                sd_reg[k+1] <= sd_reg[k];
            end
        end

        if (k < 31)
        begin : g_v
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sv_reg[k+1] <= ge_next ? sv_reg[k] - trial_next : sv_reg[k];
                end
            end
        end
    end

    // arc cosine by vectoring cordic
    vec_t ax_reg [0:N-1];
    vec_t ay_reg [0:N-1];
    vec_t az_reg [0:N];
    vec_t root_next;
    vec_t dw_next;

    always_comb
    begin
        root_next = $signed({3'b0, sr_reg[32][30:0]});
        dw_next   = 34'(sd_reg[32]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sd_reg[32][31])
            begin
                ax_reg[0] <= root_next;
                ay_reg[0] <= -dw_next;
                az_reg[0] <= 34'sd1073741824;
            end
            else
            begin
                ax_reg[0] <= dw_next;
                ay_reg[0] <= root_next;
                az_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_acos
        vec_t x_next;
        vec_t y_next;
        vec_t z_next;

        always_comb
        begin
            if (ay_reg[i] > 0)
            begin
                x_next = ax_reg[i] + (ay_reg[i] >>> i);
                y_next = ay_reg[i] - (ax_reg[i] >>> i);
                z_next = az_reg[i] + $signed({2'b0, ATAN_TURNS[i]});
            end
            else
            begin
                x_next = ax_reg[i] - (ay_reg[i] >>> i);
                y_next = ay_reg[i] + (ax_reg[i] >>> i);
                z_next = az_reg[i] - $signed({2'b0, ATAN_TURNS[i]});
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                az_reg[i+1] <= z_next;
            end
        end

        if (i < N - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ax_reg[i+1] <= x_next;
                    ay_reg[i+1] <= y_next;
                end
            end
        end
    end

    // angle to meters, divide by 625 with a reciprocal and correction, saturate, zero for identical points
    logic [31:0]        zc_next;
    logic [61:0]        prod_reg;
    logic [35:0]        n2_next;
    logic [33:0]        n2_reg;
    logic               sat_reg;
    logic [44:0]        qp_next;
    logic [33:0]        n3_reg;
    logic               sat3_reg;
    logic [24:0]        qh_reg;
    logic signed [35:0] rem_reg;
    logic [24:0]        qh4_reg;
    logic               sat4_reg;
    logic signed [2:0]  adj_next;
    logic signed [26:0] q_next;
    logic [24:0]        dist_next;
    logic [24:0]        dist_reg;

    always_comb
    begin
        zc_next  = az_reg[N][33] ? 32'd0 : az_reg[N][31:0];
        n2_next  = 36'((63'(prod_reg) + METER_HALF) >> 27);
        qp_next  = 45'(n2_reg[33:10]) * 45'(RECIP_625);
        adj_next = 3'(rem_reg >= 36'sd625) + 3'(rem_reg >= 36'sd1250)
                 - 3'(rem_reg < 36'sd0) - 3'(rem_reg < -36'sd625);
        q_next   = $signed({2'b0, qh4_reg}) + 27'(adj_next);
        if (eq_reg[LAST-1])
        begin
            dist_next = '0;
        end
        else if (sat4_reg)
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = q_next[24:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= 62'(zc_next) * 62'(METER_SCALE);
            n2_reg   <= n2_next[33:0];
            sat_reg  <= n2_next >= SAT_LIMIT;
            qh_reg   <= qp_next[44:20];
            n3_reg   <= n2_reg;
            sat3_reg <= sat_reg;
            rem_reg  <= $signed({2'b0, n3_reg}) - $signed(36'(36'(qh_reg) * 36'd625));
            qh4_reg  <= qh_reg;
            sat4_reg <= sat3_reg;
            dist_reg <= dist_next;
        end
    end

    assign distance_m = dist_reg;

    a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST] && eq_reg[LAST] |-> distance_m == '0)
        else $error("identical points gave a nonzero distance");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_m <= DIST_MAX)
        else $error("distance above saturation limit");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_P3] |-> (d_reg <= 32'sd1073741824) && (d_reg >= -32'sd1073741824))
        else $error("dot product outside unit range");

    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_SQ] |-> sr_reg[32] <= 63'd1073741824)
        else $error("square root above one");

endmodule
